@@ rtl/core/palette_entry_colour_converter_defines.svh @@
// ----------------------------------------------------------------------------
// Palette entry colour converter - assertion macros
// Shared check macros, sampled on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PALETTE_ENTRY_COLOUR_CONVERTER_DEFINES_SVH
`define PALETTE_ENTRY_COLOUR_CONVERTER_DEFINES_SVH

// Same-cycle implication
`define PECC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pecc: same-cycle check failed");

// Next-cycle implication
`define PECC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pecc: next-cycle check failed");

`endif

@@ rtl/core/pecc_pkg.sv @@
// ----------------------------------------------------------------------------
// pecc_pkg
// Types, constants and arithmetic helpers of the palette colour converter.
// ----------------------------------------------------------------------------
package pecc_pkg;

   localparam int EntryWidth    = 8;
   localparam int PaletteDepth  = 1 << EntryWidth;
   localparam int ChanWidth     = 6;
   localparam int ChanMax       = 63;
   localparam int BaseWidth     = 7;
   localparam int NumBases      = 3;
   localparam int CsrIndexWidth = 2;
   localparam int YuvWidth      = 32;
   localparam int AccWidth      = 25;
   localparam int MulAWidth     = 17;
   localparam int MulBWidth     = 8;
   localparam int StepWidth     = 10;
   localparam int RampDiv       = 63;
   localparam int RampTop       = 64;
   localparam int RoundBias     = 16384;
   localparam int ChromaOffset  = 128;
   localparam int RamWidth      = 3 * ChanWidth + YuvWidth;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_RED_BASE   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_GREEN_BASE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BLUE_BASE  = 2'd2;

   // channel lanes and YUV component groups
   localparam logic [1:0] LANE_RED   = 2'd0;
   localparam logic [1:0] LANE_GREEN = 2'd1;
   localparam logic [1:0] LANE_BLUE  = 2'd2;
   localparam logic [1:0] GRP_Y      = 2'd0;
   localparam logic [1:0] GRP_U      = 2'd1;
   localparam logic [1:0] GRP_V      = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_RAMP,
      ST_MAC,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 kind;
      logic [EntryWidth-1:0] entry;
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } req_item_type;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
      logic [YuvWidth-1:0]  yuy2;
   } result_type;

   typedef struct packed {
      logic                  we;
      logic [EntryWidth-1:0] waddr;
      logic [RamWidth-1:0]   wdata;
      logic [EntryWidth-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic                        en;
      logic                        load;
      logic signed [AccWidth-1:0]  addend;
      logic signed [MulAWidth-1:0] mul_a;
      logic [MulBWidth-1:0]        mul_b;
   } mac_op_type;

   typedef logic [NumBases-1:0][BaseWidth-1:0] bases_type;

   // step = trunc(256*n/63) with n = 64 - base, i.e. 4n + floor(4n/63)
   function automatic logic [StepWidth-1:0] ramp_step(input logic [BaseWidth-1:0] base);
      logic [7:0]           n;
      logic [StepWidth-1:0] q4;
      logic [3:0]           q;
      n  = 8'(RampTop) - {base[BaseWidth-1], base};
      q4 = {n, 2'b00};
      q  = '0;
      for (int k = 1; k <= 8; k++) begin
         if (q4 >= StepWidth'(RampDiv * k)) begin
            q = q + 4'd1;
         end
      end
      return q4 + StepWidth'(q);
   endfunction

   function automatic logic signed [AccWidth-1:0] ramp_start(
      input logic [BaseWidth-1:0] base);
      return signed'({{(AccWidth-BaseWidth-8){base[BaseWidth-1]}}, base, 8'h00});
   endfunction

   function automatic logic [ChanWidth-1:0] ramp_clamp(input logic signed [AccWidth-1:0] v);
      logic [AccWidth-10:0] hi;
      hi = v[AccWidth-2:8];
      if (v[AccWidth-1]) begin
         return '0;
      end else if (hi > (AccWidth-9)'(ChanMax)) begin
         return ChanWidth'(ChanMax);
      end else begin
         return hi[ChanWidth-1:0];
      end
   endfunction

   // floor(acc / 32768) plus offset, clamped to a byte (bias already in acc)
   function automatic logic [7:0] clamp_byte(input logic signed [AccWidth-1:0] acc,
                                             input logic chroma);
      logic signed [AccWidth-16:0] s;
      logic signed [AccWidth-15:0] t;
      s = acc[AccWidth-1:15];
      t = {s[AccWidth-16], s} + (chroma ? (AccWidth-14)'(ChromaOffset) : '0);
      if (t < 0) begin
         return 8'h00;
      end else if (t > (AccWidth-14)'(255)) begin
         return 8'hff;
      end else begin
         return t[7:0];
      end
   endfunction

   // BT.601 coefficients, scaled by 32768
   function automatic logic signed [MulAWidth-1:0] yuv_coef(input logic [1:0] grp,
                                                            input logic [1:0] lane);
      logic signed [MulAWidth-1:0] c;
      case ({grp, lane})
         {GRP_Y, LANE_RED}:   c = 17'sd9798;
         {GRP_Y, LANE_GREEN}: c = 17'sd19235;
         {GRP_Y, LANE_BLUE}:  c = 17'sd3736;
         {GRP_U, LANE_RED}:   c = -17'sd4784;
         {GRP_U, LANE_GREEN}: c = -17'sd9437;
         {GRP_U, LANE_BLUE}:  c = 17'sd14221;
         {GRP_V, LANE_RED}:   c = 17'sd20218;
         {GRP_V, LANE_GREEN}: c = -17'sd16941;
         {GRP_V, LANE_BLUE}:  c = -17'sd3277;
         default:             c = '0;
      endcase
      return c;
   endfunction

endpackage

@@ rtl/core/pecc_chan_if.sv @@
// ----------------------------------------------------------------------------
// pecc_chan_if
// Valid/ready channels of the converter: request and response.
// ----------------------------------------------------------------------------
interface pecc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic [pecc_pkg::EntryWidth-1:0]   entry;
   logic [pecc_pkg::ChanWidth-1:0]    red_in;
   logic [pecc_pkg::ChanWidth-1:0]    green_in;
   logic [pecc_pkg::ChanWidth-1:0]    blue_in;

   modport source (output valid, kind, entry, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, entry, red_in, green_in, blue_in, output ready);
endinterface

interface pecc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pecc_pkg::ChanWidth-1:0]    red_out;
   logic [pecc_pkg::ChanWidth-1:0]    green_out;
   logic [pecc_pkg::ChanWidth-1:0]    blue_out;
   logic [14:0]                       word_rgb555;
   logic [15:0]                       word_rgb565;
   logic [23:0]                       word_rgb888;
   logic [pecc_pkg::YuvWidth-1:0]     word_yuy2;

   modport source (output valid, red_out, green_out, blue_out, word_rgb555, word_rgb565,
                   word_rgb888, word_yuy2, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, word_rgb555, word_rgb565,
                   word_rgb888, word_yuy2, output ready);
endinterface

@@ rtl/core/palette_entry_colour_converter.sv @@
// ----------------------------------------------------------------------------
// palette_entry_colour_converter
// 256-entry palette with ramp mapping and RGB/YUY2 result formats.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per item: kind 0 writes entry with the
//   ramp-mapped red_in/green_in/blue_in, kind 1 reads entry back.
//   rsp_chan returns exactly one transaction per request: the stored channels
//   and the RGB555, RGB565, RGB888 and YUY2 words of that entry.
//   csr_we/csr_index/csr_wdata set the red, green and blue ramp bases; write
//   them only while no transaction is outstanding. Unknown indexes are ignored.
// Timing:
//   A read passes from acceptance through the palette RAM read register and
//   the working registers to the output register, which drives rsp valid. A
//   write runs 3 ramp steps and 9 YUV multiply-accumulate steps on the one
//   shared MAC, the palette write, then the output register. One item is in
//   work at a time; req ready drops from acceptance and returns the cycle
//   after the result moves into the output register.
// Reset:
//   Synchronous, active high. Bases clear to 0 and every palette entry reads as
//   zero until written; no clearing pass is needed.
//   A stalled rsp_chan holds its transaction and the sequencer waits behind it.
// ----------------------------------------------------------------------------
module palette_entry_colour_converter (
   input  logic                                 clock,
   input  logic                                 reset,
   pecc_req_if.sink                             req_chan,
   pecc_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [pecc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [pecc_pkg::BaseWidth-1:0]       csr_wdata
);

   pecc_pkg::bases_type                     bases_ff;
   pecc_pkg::req_item_type                  req_item;
   pecc_pkg::result_type                    result;
   pecc_pkg::result_type                    rsp_data_ff;
   pecc_pkg::ram_req_type                   ram_req;
   pecc_pkg::mac_op_type                    mac_op;
   logic [pecc_pkg::RamWidth-1:0]           ram_rdata;
   logic signed [pecc_pkg::AccWidth-1:0]    mac_sum;
   logic                                    req_ready;
   logic                                    res_valid;
   logic                                    res_taken;
   logic                                    rsp_valid_ff, rsp_valid_in;

   assign req_item.kind  = req_chan.kind;
   assign req_item.entry = req_chan.entry;
   assign req_item.red   = req_chan.red_in;
   assign req_item.green = req_chan.green_in;
   assign req_item.blue  = req_chan.blue_in;
   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bases_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pecc_pkg::CSR_RED_BASE:   bases_ff[0] <= csr_wdata;
            pecc_pkg::CSR_GREEN_BASE: bases_ff[1] <= csr_wdata;
            pecc_pkg::CSR_BLUE_BASE:  bases_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   pecc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .bases     (bases_ff),
      .res_valid (res_valid),
      .result    (result),
      .res_taken (res_taken),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .mac_op    (mac_op),
      .mac_sum   (mac_sum)
   );

   pecc_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .sum   (mac_sum)
   );

   pecc_ram #(
      .Width (pecc_pkg::RamWidth),
      .Depth (pecc_pkg::PaletteDepth)
   ) u_palette (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // output register: refills when empty or being emptied this cycle
   assign res_taken    = res_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = res_taken || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.red_out     = rsp_data_ff.red;
   assign rsp_chan.green_out   = rsp_data_ff.green;
   assign rsp_chan.blue_out    = rsp_data_ff.blue;
   // (c*4)>>3 is c>>1, (c*4)>>2 is c
   assign rsp_chan.word_rgb555 = {rsp_data_ff.red[5:1], rsp_data_ff.green[5:1],
                                  rsp_data_ff.blue[5:1]};
   assign rsp_chan.word_rgb565 = {rsp_data_ff.red[5:1], rsp_data_ff.green,
                                  rsp_data_ff.blue[5:1]};
   assign rsp_chan.word_rgb888 = {rsp_data_ff.red, 2'b00, rsp_data_ff.green, 2'b00,
                                  rsp_data_ff.blue, 2'b00};
   assign rsp_chan.word_yuy2   = rsp_data_ff.yuy2;

endmodule

@@ rtl/core/pecc_ram.sv @@
// ----------------------------------------------------------------------------
// pecc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pecc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/pecc_mac.sv @@
// ----------------------------------------------------------------------------
// pecc_mac
// Shared multiply-accumulate unit: sum = (load ? addend : acc) + a * b.
// ----------------------------------------------------------------------------
module pecc_mac (
   input  logic                                    clock,
   input  pecc_pkg::mac_op_type                    op,
   output logic signed [pecc_pkg::AccWidth-1:0]    sum
);

   logic signed [pecc_pkg::AccWidth-1:0]                      acc_ff;
   logic signed [pecc_pkg::AccWidth-1:0]                      acc_in;
   logic signed [pecc_pkg::MulAWidth+pecc_pkg::MulBWidth:0]   prod;
   logic signed [pecc_pkg::AccWidth-1:0]                      base;

   always_comb begin
      prod   = op.mul_a * $signed({1'b0, op.mul_b});
      base   = op.load ? op.addend : acc_ff;
      acc_in = base + $signed(prod[pecc_pkg::AccWidth-1:0]);
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign sum = acc_in;

endmodule

@@ rtl/core/pecc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pecc_ctrl
// Sequencer: ramp mapping and YUV sums through the shared MAC, palette access.
// ----------------------------------------------------------------------------
`include "palette_entry_colour_converter_defines.svh"

module pecc_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pecc_pkg::req_item_type               req_item,
   input  pecc_pkg::bases_type                  bases,
   output logic                                 res_valid,
   output pecc_pkg::result_type                 result,
   input  logic                                 res_taken,
   output pecc_pkg::ram_req_type                ram_req,
   input  logic [pecc_pkg::RamWidth-1:0]        ram_rdata,
   output pecc_pkg::mac_op_type                 mac_op,
   input  logic signed [pecc_pkg::AccWidth-1:0] mac_sum
);

   pecc_pkg::state_type                     state_ff, state_in;
   logic                                    kind_ff;
   logic [pecc_pkg::EntryWidth-1:0]         entry_ff;
   logic [2:0][pecc_pkg::ChanWidth-1:0]     raw_ff;
   logic [2:0][pecc_pkg::ChanWidth-1:0]     chan_ff;
   logic [pecc_pkg::YuvWidth-1:0]           yuv_ff;
   logic [1:0]                              lane_ff;
   logic [1:0]                              grp_ff;
   logic [pecc_pkg::PaletteDepth-1:0]       valid_ff;
   logic                                    accept;
   logic                                    lane_last;
   logic [pecc_pkg::BaseWidth-1:0]          base_sel;
   logic [7:0]                              yuv_byte;
   pecc_pkg::result_type                    ram_word;

   assign accept    = req_valid && req_ready;
   assign lane_last = (lane_ff == pecc_pkg::LANE_BLUE);
   assign base_sel  = bases[lane_ff];
   assign yuv_byte  = pecc_pkg::clamp_byte(mac_sum, grp_ff != pecc_pkg::GRP_Y);
   assign ram_word  = pecc_pkg::result_type'(ram_rdata);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pecc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_item.kind == pecc_pkg::KIND_WRITE) ? pecc_pkg::ST_RAMP
                                                                  : pecc_pkg::ST_READ;
            end
         end
         pecc_pkg::ST_READ:  state_in = pecc_pkg::ST_DONE;
         pecc_pkg::ST_RAMP: begin
            if (lane_last) state_in = pecc_pkg::ST_MAC;
         end
         pecc_pkg::ST_MAC: begin
            if (lane_last && grp_ff == pecc_pkg::GRP_V) state_in = pecc_pkg::ST_WRITE;
         end
         pecc_pkg::ST_WRITE: state_in = pecc_pkg::ST_DONE;
         pecc_pkg::ST_DONE: begin
            if (res_taken) state_in = pecc_pkg::ST_IDLE;
         end
         default:            state_in = pecc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      ram_req.we    = 1'b0;
      ram_req.waddr = entry_ff;
      ram_req.wdata = {chan_ff[0], chan_ff[1], chan_ff[2], yuv_ff};
      ram_req.raddr = entry_ff;
      mac_op.en     = 1'b0;
      mac_op.load   = 1'b1;
      mac_op.addend = pecc_pkg::ramp_start(base_sel);
      mac_op.mul_a  = signed'(pecc_pkg::MulAWidth'(pecc_pkg::ramp_step(base_sel)));
      mac_op.mul_b  = pecc_pkg::MulBWidth'(raw_ff[lane_ff]);
      case (state_ff)
         pecc_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            ram_req.raddr = req_item.entry;
         end
         pecc_pkg::ST_RAMP: begin
            mac_op.en = 1'b1;
         end
         pecc_pkg::ST_MAC: begin
            mac_op.en     = 1'b1;
            mac_op.load   = (lane_ff == pecc_pkg::LANE_RED);
            mac_op.addend = pecc_pkg::AccWidth'(pecc_pkg::RoundBias);
            mac_op.mul_a  = pecc_pkg::yuv_coef(grp_ff, lane_ff);
            mac_op.mul_b  = {chan_ff[lane_ff], 2'b00};
         end
         pecc_pkg::ST_WRITE: begin
            ram_req.we = 1'b1;
         end
         pecc_pkg::ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pecc_pkg::ST_IDLE;
         valid_ff <= '0;
         lane_ff  <= pecc_pkg::LANE_RED;
         grp_ff   <= pecc_pkg::GRP_Y;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            lane_ff <= pecc_pkg::LANE_RED;
            grp_ff  <= pecc_pkg::GRP_Y;
         end else if (state_ff == pecc_pkg::ST_RAMP || state_ff == pecc_pkg::ST_MAC) begin
            lane_ff <= lane_last ? pecc_pkg::LANE_RED : lane_ff + 2'd1;
            if (state_ff == pecc_pkg::ST_MAC && lane_last) begin
               grp_ff <= grp_ff + 2'd1;
            end
         end
         if (state_ff == pecc_pkg::ST_WRITE) begin
            valid_ff[entry_ff] <= 1'b1;
         end
      end
   end

   // item payload and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_item.kind;
         entry_ff  <= req_item.entry;
         raw_ff[0] <= req_item.red;
         raw_ff[1] <= req_item.green;
         raw_ff[2] <= req_item.blue;
      end
      case (state_ff)
         pecc_pkg::ST_RAMP: begin
            chan_ff[lane_ff] <= pecc_pkg::ramp_clamp(mac_sum);
         end
         pecc_pkg::ST_MAC: begin
            if (lane_last) begin
               case (grp_ff)
                  pecc_pkg::GRP_Y: begin
                     yuv_ff[23:16] <= yuv_byte;
                     yuv_ff[7:0]   <= yuv_byte;
                  end
                  pecc_pkg::GRP_U: yuv_ff[15:8]  <= yuv_byte;
                  default:         yuv_ff[31:24] <= yuv_byte;
               endcase
            end
         end
         pecc_pkg::ST_READ: begin
            // never-written entries read as the cleared palette
            if (valid_ff[entry_ff]) begin
               chan_ff[0] <= ram_word.red;
               chan_ff[1] <= ram_word.green;
               chan_ff[2] <= ram_word.blue;
               yuv_ff     <= ram_word.yuy2;
            end else begin
               chan_ff <= '0;
               yuv_ff  <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign result.red   = chan_ff[0];
   assign result.green = chan_ff[1];
   assign result.blue  = chan_ff[2];
   assign result.yuy2  = yuv_ff;

   `PECC_ASSERT_NOW(a_ram_write_for_write_kind, ram_req.we, kind_ff == pecc_pkg::KIND_WRITE)
   `PECC_ASSERT_NEXT(a_write_starts_ramp, accept && req_item.kind == pecc_pkg::KIND_WRITE, state_ff == pecc_pkg::ST_RAMP)
   `PECC_ASSERT_NOW(a_lane_in_range, state_ff == pecc_pkg::ST_RAMP || state_ff == pecc_pkg::ST_MAC, lane_ff != 2'd3 && grp_ff != 2'd3)
   `PECC_ASSERT_NEXT(a_entry_marked_valid, ram_req.we, valid_ff[entry_ff])

endmodule
